[hw/rtl/bss_pkg.sv]
`timescale 1ns / 1ps
package bss_pkg;

  localparam int NEEDLE_MAX = 16;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 4;
  localparam int LEN_W    = 5;
  localparam int RES_OFF_W = 32;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic MODE_NEEDLE = 1'b0;
  localparam logic MODE_HAY    = 1'b1;

  typedef enum logic {
    OP_NEEDLE,
    OP_HAY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              wr_ok;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

[hw/rtl/bss_front.sv]
`timescale 1ns / 1ps
module bss_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic [bss_pkg::IDX_W-1:0] in_needle_index,
  input  logic [bss_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                      in_last_byte,
  output bss_pkg::head_t            head,
  input  logic                      pop
);
  import bss_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             cls;
  logic              push;

  // Decode the incoming item into the form the back end executes.
  always_comb begin
    cls.op    = (in_mode == MODE_HAY) ? OP_HAY : OP_NEEDLE;
    cls.wr_ok = (in_mode == MODE_NEEDLE) && (int'(in_needle_index) < NEEDLE_MAX);
    cls.idx   = in_needle_index;
    cls.data  = in_data_byte;
    cls.last  = (in_mode == MODE_HAY) && in_last_byte;
  end

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[hw/rtl/bss_back.sv]
`timescale 1ns / 1ps
module bss_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bss_pkg::head_t                head,
  output logic                          pop,
  input  logic [bss_pkg::LEN_W-1:0]     needle_len,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [bss_pkg::RES_OFF_W-1:0] out_match_offset
);
  import bss_pkg::*;

  logic [BYTE_W-1:0]      needle_r [NEEDLE_MAX];
  logic [BYTE_W-1:0]      win_r    [NEEDLE_MAX];
  logic [BYTE_W-1:0]      win_nxt  [NEEDLE_MAX];
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt;
  logic                   match_r, match_nxt;
  logic [OFFSET_BITS-1:0] first_r, first_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r;
  logic [RES_OFF_W-1:0]   out_off_r;
  logic [NEEDLE_MAX-1:0]  len_hit;
  logic                   sel_hit;
  logic                   len_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] hit_off;
  logic                   is_hay;
  logic                   emits;
  logic                   out_free;

  assign is_hay   = (head.item.op == OP_HAY);
  assign emits    = is_hay && head.item.last;
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head.valid && (!emits || out_free);

  always_comb begin
    win_nxt[0] = head.item.data;
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Each candidate length compares the newest bytes against the needle.
  always_comb begin
    len_hit = '0;
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      len_hit[l-1] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_nxt[l-1-i] != needle_r[i]) begin
          len_hit[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    sel_hit = 1'b0;
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      if (int'(needle_len) == l) begin
        sel_hit = len_hit[l-1];
      end
    end
  end

  always_comb begin
    cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + OFFSET_BITS'(1);
    len_ext = {{(OFFSET_BITS-LEN_W){1'b0}}, needle_len};
    len_ok  = (needle_len != '0) && (int'(needle_len) <= NEEDLE_MAX) && (cnt_nxt >= len_ext);
    hit     = len_ok && sel_hit;
    hit_off = cnt_nxt - len_ext;
  end

  always_comb begin
    match_nxt     = match_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop && is_hay) begin
      if (!match_r && hit) begin
        match_nxt = 1'b1;
        first_nxt = hit_off;
      end
      if (emits) begin
        out_valid_nxt = 1'b1;
        match_nxt     = 1'b0;
        first_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      match_r     <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      match_r     <= match_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop && is_hay) begin
        if (emits) begin
          cnt_r <= '0;
          for (int k = 0; k < NEEDLE_MAX; k++) begin
            win_r[k] <= '0;
          end
        end else begin
          cnt_r <= cnt_nxt;
          for (int k = 0; k < NEEDLE_MAX; k++) begin
            win_r[k] <= win_nxt[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      out_found_r <= match_r || hit;
      if (match_r) begin
        out_off_r <= RES_OFF_W'(first_r);
      end else if (hit) begin
        out_off_r <= RES_OFF_W'(hit_off);
      end else begin
        out_off_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      if (pop && !is_hay && head.item.wr_ok && (int'(head.item.idx) == j)) begin
        needle_r[j] <= head.item.data;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_off_r;

endmodule

[hw/rtl/byte_substring_search.sv]
`timescale 1ns / 1ps
// Streams a haystack one byte per item and reports the first position at which the loaded
// needle occurs. Needle bytes are loaded by mode-0 items, haystack bytes arrive as mode-1
// items, and the mode-1 item flagged last produces one result with the found flag and the
// match offset, after which the block is ready for the next haystack. One item is
// accepted every cycle while the queue has room; the rate is set by the back end, which
// shifts the byte window and compares it with the needle for every candidate length. A
// result is registered once its last byte leaves the queue. A two-entry queue between the
// input side and the compare logic lets other items keep flowing while a result waits on
// the output; a further last byte waits in the queue until the pending result is taken.
module byte_substring_search #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bss_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [bss_pkg::IDX_W-1:0]     in_needle_index,
  input  logic [bss_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [bss_pkg::RES_OFF_W-1:0] out_match_offset
);
  import bss_pkg::*;

  logic [LEN_W-1:0] needle_len_r, needle_len_nxt;
  head_t            head;
  logic             pop;

  assign needle_len_nxt = cfg_wr_en ? cfg_wr_data : needle_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_len_r <= LEN_W'(1);
    end else begin
      needle_len_r <= needle_len_nxt;
    end
  end

  bss_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_needle_index(in_needle_index),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .head           (head),
    .pop            (pop)
  );

  bss_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .needle_len      (needle_len_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_offset(out_match_offset)
  );

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && head.item.op == OP_HAY && head.item.last && out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_offset == '0))
    else $error("nonzero offset on a not-found result");

endmodule
